[hdl/ppta_pkg.sv]
// ----------------------------------------------------------------------------
// ppta_pkg: shared types and constants for the polygon point test block
// Command codes, controller states and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ppta_pkg;

  // Width of the doubled-area result
  localparam int unsigned AREA_W = 34;

  // Command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ISSUE  = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_RESULT = 2'd3
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take a new command beat
    logic issue;    // issue one vertex read
    logic load;     // form the result registers
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;    // vertex table empty
    logic last_issue;  // current read is the last of the walk
    logic pipe_busy;   // edge pipeline still holds work
  } dp_stat_t;

endpackage

`default_nettype wire

[hdl/ppta_ctrl.sv]
// ----------------------------------------------------------------------------
// ppta_ctrl: command sequencer
// Accepts one command beat, steps the datapath through the vertex walk,
// waits for the edge pipeline to empty and strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ppta_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [1:0]           command_i,
  input  wire ppta_pkg::dp_stat_t   stat_i,
  output      ppta_pkg::ctrl_cmd_t  cmd_o,
  output      logic                 busy_o,
  output      logic                 done_o
);
  import ppta_pkg::*;

  state_e    state_q, state_d;
  ctrl_cmd_t cmd;
  logic      walk_cmd;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Test and report walk the table unless it is empty
  assign walk_cmd = ((command_i == CMD_TEST) || (command_i == CMD_REPORT)) && !stat_i.cnt_zero;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd.capture = 1'b0;
    cmd.issue   = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd.capture = 1'b1;
          state_d     = walk_cmd ? ST_ISSUE : ST_DRAIN;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          cmd.load = 1'b1;
          state_d  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESULT);

endmodule

`default_nettype wire

[hdl/ppta_dp.sv]
// ----------------------------------------------------------------------------
// ppta_dp: vertex table and edge pipeline
// Holds the vertex memory and count, walks the edges one per cycle through
// a pipeline (read, differences, products, crossing compare and shoelace
// term, accumulate) and forms the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ppta_dp #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ppta_pkg::ctrl_cmd_t               cmd_i,
  input  wire logic [1:0]                        command_i,
  input  wire logic signed [COORD_BITS-1:0]      coord_x_i,
  input  wire logic signed [COORD_BITS-1:0]      coord_y_i,
  output      ppta_pkg::dp_stat_t                stat_o,
  output      logic                              status_o,
  output      logic                              inside_res_o,
  output      logic [ppta_pkg::AREA_W-1:0]       doubled_area_o,
  output      logic signed [COORD_BITS-1:0]      min_x_o,
  output      logic signed [COORD_BITS-1:0]      max_x_o,
  output      logic signed [COORD_BITS-1:0]      min_y_o,
  output      logic signed [COORD_BITS-1:0]      max_y_o,
  output      logic signed [COORD_BITS-1:0]      mid_x_o,
  output      logic signed [COORD_BITS-1:0]      mid_y_o
);
  import ppta_pkg::*;

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned AW   = $clog2(MAX_VERTICES);
  localparam int unsigned CW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned PW   = 2 * C + 2;                    // crossing products
  localparam int unsigned TW   = 2 * C + 1;                    // shoelace term
  localparam int unsigned ACCW = TW + CW;                      // shoelace sum
  localparam int unsigned MW   = (ACCW > AREA_W) ? ACCW : AREA_W + 1;
  localparam logic [MW-1:0]     AREA_MAX = {{(MW-AREA_W){1'b0}}, {AREA_W{1'b1}}};
  localparam logic [CW-1:0]     CNT_MAX  = CW'(MAX_VERTICES);
  localparam logic [CW-1:0]     CNT_ONE  = CW'(1);
  localparam logic [CW-1:0]     CNT_TWO  = CW'(2);

  // Vertex memory, {x, y} per entry
  logic [2*C-1:0] mem_q [MAX_VERTICES];

  // Control state
  logic [CW-1:0]  cnt_q;
  logic [AW-1:0]  rd_addr_q;
  logic           first_q;
  logic           v0_q, f0_q, v1_q, v2_q, v3_q;

  // Captured command
  logic [1:0]             cmd_q;
  logic signed [C-1:0]    qx_q, qy_q;
  logic                   full_q;

  // Pipeline payload
  logic [2*C-1:0]         rd_q;
  logic signed [C-1:0]    px_q, py_q;
  logic signed [C-1:0]    mnx_q, mxx_q, mny_q, mxy_q;
  logic signed [C:0]      dx_q, dd_q, dxj_q, ey_q;
  logic signed [C-1:0]    xi1_q, yi1_q, xj1_q, yj1_q;
  logic                   cr1_q, cr2_q;
  logic signed [PW-1:0]   p1_q, p2_q;
  logic signed [2*C-1:0]  a1_q, a2_q;
  logic signed [TW-1:0]   term_q;
  logic signed [ACCW-1:0] acc_q;
  logic                   parity_q;

  // Result registers
  logic                   status_q, inside_q;
  logic [AREA_W-1:0]      area_q;
  logic signed [C-1:0]    rmnx_q, rmxx_q, rmny_q, rmxy_q, rmidx_q, rmidy_q;

  logic [CW-1:0]          cnt_m1;
  logic signed [C-1:0]    cx, cy;
  logic signed [C:0]      dyr, eyr;
  logic signed [C:0]      sumx, sumy, halfx, halfy;
  logic [MW-1:0]          mag;
  logic                   inbox;
  logic                   full;

  assign full   = (cnt_q == CNT_MAX);
  assign cnt_m1 = cnt_q - CNT_ONE;
  assign cx     = $signed(rd_q[2*C-1:C]);
  assign cy     = $signed(rd_q[C-1:0]);

  // Status to the controller
  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.last_issue = !first_q && (CW'(rd_addr_q) == cnt_m1);
  assign stat_o.pipe_busy  = v0_q | v1_q | v2_q | v3_q;

  // Vertex count, read address and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_addr_q <= '0;
      first_q   <= 1'b0;
      v0_q      <= 1'b0;
      f0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        // walk starts at the last vertex so the closing edge comes first
        rd_addr_q <= cnt_m1[AW-1:0];
        first_q   <= 1'b1;
        if (command_i == CMD_CLEAR) begin
          cnt_q <= '0;
        end else if ((command_i == CMD_APPEND) && !full) begin
          cnt_q <= cnt_q + CNT_ONE;
        end
      end else if (cmd_i.issue) begin
        first_q   <= 1'b0;
        rd_addr_q <= first_q ? '0 : rd_addr_q + AW'(1);
      end
      v0_q <= cmd_i.issue;
      f0_q <= cmd_i.issue & first_q;
      v1_q <= v0_q & !f0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Vertex memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && (command_i == CMD_APPEND) && !full) begin
      mem_q[cnt_q[AW-1:0]] <= {coord_x_i, coord_y_i};
    end
    rd_q <= mem_q[rd_addr_q];
  end

  // Edge differences, sign-normalized so the y span is non-negative
  always_comb begin
    dyr = (C+1)'(py_q) - (C+1)'(cy);
    eyr = (C+1)'(qy_q) - (C+1)'(cy);
    if (dyr < 0) begin
      dyr = -dyr;
      eyr = -eyr;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      qx_q     <= coord_x_i;
      qy_q     <= coord_y_i;
      full_q   <= full;
      parity_q <= 1'b0;
      acc_q    <= '0;
    end
    // stage 1: bounds, differences, previous vertex
    if (v0_q) begin
      px_q <= cx;
      py_q <= cy;
      if (f0_q) begin
        mnx_q <= cx;
        mxx_q <= cx;
        mny_q <= cy;
        mxy_q <= cy;
      end else begin
        if (cx < mnx_q) mnx_q <= cx;
        if (cx > mxx_q) mxx_q <= cx;
        if (cy < mny_q) mny_q <= cy;
        if (cy > mxy_q) mxy_q <= cy;
      end
    end
    cr1_q <= (cy > qy_q) != (py_q > qy_q);
    dx_q  <= (C+1)'(qx_q) - (C+1)'(cx);
    dxj_q <= (C+1)'(px_q) - (C+1)'(cx);
    dd_q  <= dyr;
    ey_q  <= eyr;
    xi1_q <= cx;
    yi1_q <= cy;
    xj1_q <= px_q;
    yj1_q <= py_q;
    // stage 2: products
    cr2_q <= cr1_q;
    p1_q  <= dx_q * dd_q;
    p2_q  <= dxj_q * ey_q;
    a1_q  <= xj1_q * yi1_q;
    a2_q  <= xi1_q * yj1_q;
    // stage 3: crossing compare and shoelace term
    if (v2_q && cr2_q && (p1_q < p2_q)) begin
      parity_q <= !parity_q;
    end
    term_q <= TW'(a1_q) - TW'(a2_q);
    // stage 4: accumulate
    if (v3_q) begin
      acc_q <= acc_q + ACCW'(term_q);
    end
  end

  // Result formation
  assign inbox = (qx_q >= mnx_q) && (qx_q <= mxx_q) && (qy_q >= mny_q) && (qy_q <= mxy_q);
  assign sumx  = (C+1)'(mnx_q) + (C+1)'(mxx_q);
  assign sumy  = (C+1)'(mny_q) + (C+1)'(mxy_q);
  assign halfx = (sumx + (C+1)'({1'b0, sumx[C]})) >>> 1;
  assign halfy = (sumy + (C+1)'({1'b0, sumy[C]})) >>> 1;
  assign mag   = (acc_q < 0) ? MW'(-acc_q) : MW'(acc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= (cmd_q == CMD_APPEND) && full_q;
      inside_q <= 1'b0;
      area_q   <= '0;
      rmnx_q   <= '0;
      rmxx_q   <= '0;
      rmny_q   <= '0;
      rmxy_q   <= '0;
      rmidx_q  <= '0;
      rmidy_q  <= '0;
      if (cmd_q == CMD_TEST) begin
        // single vertex: the box collapses to the point itself
        if (cnt_q == CNT_ONE) begin
          inside_q <= inbox;
        end else if ((cnt_q != '0) && (cnt_q != CNT_TWO)) begin
          inside_q <= inbox && parity_q;
        end
      end else if ((cmd_q == CMD_REPORT) && (cnt_q != '0)) begin
        area_q  <= (mag > AREA_MAX) ? AREA_MAX[AREA_W-1:0] : mag[AREA_W-1:0];
        rmnx_q  <= mnx_q;
        rmxx_q  <= mxx_q;
        rmny_q  <= mny_q;
        rmxy_q  <= mxy_q;
        rmidx_q <= halfx[C-1:0];
        rmidy_q <= halfy[C-1:0];
      end
    end
  end

  assign status_o       = status_q;
  assign inside_res_o   = inside_q;
  assign doubled_area_o = area_q;
  assign min_x_o        = rmnx_q;
  assign max_x_o        = rmxx_q;
  assign min_y_o        = rmny_q;
  assign max_y_o        = rmxy_q;
  assign mid_x_o        = rmidx_q;
  assign mid_y_o        = rmidy_q;

endmodule

`default_nettype wire

[hdl/polygon_point_test_and_area.sv]
// Clear and append skip the walk: the beat goes to the drain state, then the result strobe.
// Test and report walk the table (N = stored vertices) and strobe once the edge pipeline drains.
// The single vertex memory read port walks N+1 reads, one edge per cycle, into the edge pipeline.
// An empty table skips the walk and answers like clear. A new beat is taken only once idle again.
// Reset empties the vertex table; memory contents are kept and never read unwritten.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// polygon_point_test_and_area: polygon vertex table with point test and area
// Stores vertices, tests a query point by even-odd ray casting behind a
// bounding-box reject, and reports doubled area, bounds and midpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_point_test_and_area #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output      logic                          busy_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic signed [COORD_BITS-1:0]  coord_x_i,
  input  wire logic signed [COORD_BITS-1:0]  coord_y_i,
  output      logic                          done_o,
  output      logic                          status_o,
  output      logic                          inside_res_o,
  output      logic [ppta_pkg::AREA_W-1:0]   doubled_area_o,
  output      logic signed [COORD_BITS-1:0]  min_x_o,
  output      logic signed [COORD_BITS-1:0]  max_x_o,
  output      logic signed [COORD_BITS-1:0]  min_y_o,
  output      logic signed [COORD_BITS-1:0]  max_y_o,
  output      logic signed [COORD_BITS-1:0]  mid_x_o,
  output      logic signed [COORD_BITS-1:0]  mid_y_o
);
  import ppta_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // Sequencer
  ppta_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (ctrl_cmd),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  // Vertex table and edge pipeline
  ppta_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .command_i      (command_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .stat_o         (dp_stat),
    .status_o       (status_o),
    .inside_res_o   (inside_res_o),
    .doubled_area_o (doubled_area_o),
    .min_x_o        (min_x_o),
    .max_x_o        (max_x_o),
    .min_y_o        (min_y_o),
    .max_y_o        (max_y_o),
    .mid_x_o        (mid_x_o),
    .mid_y_o        (mid_y_o)
  );

endmodule

`default_nettype wire

[sim/polygon_result_checker.sv]
// ----------------------------------------------------------------------------
// polygon_result_checker: result predictor and scoreboard for the polygon block
// Watches the command channel and keeps a shadow copy of the vertex table.
// Each accepted beat yields one expected answer. Each result strobe is
// compared field by field with the oldest expected answer.
// ----------------------------------------------------------------------------
module polygon_result_checker #(
  parameter int MAX_VERTICES = 64,
  parameter int CW           = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [1:0]                   command_i,
  input  logic signed [CW-1:0]         coord_x_i,
  input  logic signed [CW-1:0]         coord_y_i,
  input  logic                         done_i,
  input  logic                         status_i,
  input  logic                         inside_res_i,
  input  logic [ppta_pkg::AREA_W-1:0]  doubled_area_i,
  input  logic signed [CW-1:0]         min_x_i,
  input  logic signed [CW-1:0]         max_x_i,
  input  logic signed [CW-1:0]         min_y_i,
  input  logic signed [CW-1:0]         max_y_i,
  input  logic signed [CW-1:0]         mid_x_i,
  input  logic signed [CW-1:0]         mid_y_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           tests_o,
  output int                           inside_o,
  output int                           reports_o,
  output int                           clipped_o,
  output int                           refused_o
);
  import ppta_pkg::*;

  localparam longint AREA_LIMIT = (longint'(1) << AREA_W) - 1;

  typedef struct {
    logic                 status;
    logic                 in_poly;
    logic [AREA_W-1:0]    area;
    logic signed [CW-1:0] min_x, max_x, min_y, max_y, mid_x, mid_y;
  } answer_t;

  // Shadow vertex table
  int vert_x [MAX_VERTICES];
  int vert_y [MAX_VERTICES];
  int vert_count = 0;

  answer_t answer_q [$];

  int fail_total = 0;
  int tests_n    = 0;
  int inside_n   = 0;
  int reports_n  = 0;
  int clipped_n  = 0;
  int refused_n  = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_total++;
  endtask

  task automatic check_field(input string name, input logic [AREA_W-1:0] got,
                             input logic [AREA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  // Min/max over the stored vertices; table must not be empty
  function automatic void find_extents(output int lo_x, output int hi_x,
                                       output int lo_y, output int hi_y);
    lo_x = vert_x[0];
    hi_x = vert_x[0];
    lo_y = vert_y[0];
    hi_y = vert_y[0];
    for (int i = 1; i < vert_count; i++) begin
      if (vert_x[i] < lo_x) lo_x = vert_x[i];
      if (vert_x[i] > hi_x) hi_x = vert_x[i];
      if (vert_y[i] < lo_y) lo_y = vert_y[i];
      if (vert_y[i] > hi_y) hi_y = vert_y[i];
    end
  endfunction

  // Even-odd ray cast toward +x, exact crossing test by cross-multiplication
  function automatic logic point_inside(input int x, input int y);
    int     lo_x, hi_x, lo_y, hi_y, j;
    longint rise, dy;
    logic   odd;
    if (vert_count == 1) return (x == vert_x[0]) && (y == vert_y[0]);
    if (vert_count < 3) return 1'b0;
    find_extents(lo_x, hi_x, lo_y, hi_y);
    if (x < lo_x || x > hi_x || y < lo_y || y > hi_y) return 1'b0;
    odd = 1'b0;
    j   = vert_count - 1;
    for (int i = 0; i < vert_count; i++) begin
      if ((vert_y[i] > y) != (vert_y[j] > y)) begin
        rise = vert_y[j] - vert_y[i];
        dy   = y - vert_y[i];
        if (rise < 0) begin
          rise = -rise;
          dy   = -dy;
        end
        if (longint'(x - vert_x[i]) * rise < longint'(vert_x[j] - vert_x[i]) * dy)
          odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  // |shoelace sum|, clipped to the result width
  function automatic logic [AREA_W-1:0] shoelace_area();
    longint acc;
    int     j;
    acc = 0;
    j   = vert_count - 1;
    for (int i = 0; i < vert_count; i++) begin
      acc += longint'(vert_x[j]) * vert_y[i] - longint'(vert_x[i]) * vert_y[j];
      j = i;
    end
    if (acc < 0) acc = -acc;
    if (acc > AREA_LIMIT) acc = AREA_LIMIT;
    return acc[AREA_W-1:0];
  endfunction

  // Apply one command beat to the shadow table and form its answer
  task automatic compute_answer(input cmd_e cmd, input int x, input int y,
                                output answer_t a);
    int lo_x, hi_x, lo_y, hi_y;
    a = '{default: 0};
    case (cmd)
      CMD_CLEAR: begin
        vert_count = 0;
      end
      CMD_APPEND: begin
        if (vert_count >= MAX_VERTICES) begin
          a.status = 1'b1;
          refused_n++;
        end else begin
          vert_x[vert_count] = x;
          vert_y[vert_count] = y;
          vert_count++;
        end
      end
      CMD_TEST: begin
        a.in_poly = point_inside(x, y);
        tests_n++;
        if (a.in_poly) inside_n++;
      end
      default: begin
        reports_n++;
        if (vert_count > 0) begin
          find_extents(lo_x, hi_x, lo_y, hi_y);
          a.area  = shoelace_area();
          a.min_x = CW'(lo_x);
          a.max_x = CW'(hi_x);
          a.min_y = CW'(lo_y);
          a.max_y = CW'(hi_y);
          // int division truncates toward zero
          a.mid_x = CW'((lo_x + hi_x) / 2);
          a.mid_y = CW'((lo_y + hi_y) / 2);
          if (longint'(a.area) == AREA_LIMIT) clipped_n++;
        end
      end
    endcase
  endtask

  // Compare results first, then take the accepted command beat
  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t want;
    if (!rst_ni) begin
      vert_count = 0;
      answer_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i === 1'b1) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result strobe with no command outstanding");
        end else begin
          want = answer_q.pop_front();
          check_field("status", status_i, want.status);
          check_field("inside_res", inside_res_i, want.in_poly);
          check_field("doubled_area", doubled_area_i, want.area);
          check_field("min_x", min_x_i, want.min_x);
          check_field("max_x", max_x_i, want.max_x);
          check_field("min_y", min_y_i, want.min_y);
          check_field("max_y", max_y_i, want.max_y);
          check_field("mid_x", mid_x_i, want.mid_x);
          check_field("mid_y", mid_y_i, want.mid_y);
        end
      end else if (done_i !== 1'b0) begin
        report_mismatch("result strobe is unknown");
      end

      if (start_i === 1'b1 && busy_i !== 1'b1) begin
        if (busy_i !== 1'b0) begin
          report_mismatch("busy is unknown while start is high");
        end else begin
          compute_answer(cmd_e'(command_i), coord_x_i, coord_y_i, want);
          answer_q = {answer_q, want};
        end
      end

      pending_o <= answer_q.size();
    end
    fail_count_o <= fail_total;
    tests_o      <= tests_n;
    inside_o     <= inside_n;
    reports_o    <= reports_n;
    clipped_o    <= clipped_n;
    refused_o    <= refused_n;
  end

endmodule

[sim/polygon_point_test_and_area_tb.sv]
// ----------------------------------------------------------------------------
// polygon_point_test_and_area_tb: top-level testbench for the polygon block
// Drives directed and random command beats (table clears, vertex appends,
// point tests, geometry reports) with random idle bursts, and takes the
// verdict from the result checker that sits beside the block.
// ----------------------------------------------------------------------------
module polygon_point_test_and_area_tb;
  import ppta_pkg::*;

  localparam int CW    = 16;
  localparam int ITEMS = 650;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 start_i   = 1'b0;
  logic [1:0]           command_i = CMD_CLEAR;
  logic signed [CW-1:0] coord_x_i = '0;
  logic signed [CW-1:0] coord_y_i = '0;

  logic                 busy_o;
  logic                 done_o;
  logic                 status_o;
  logic                 inside_res_o;
  logic [AREA_W-1:0]    doubled_area_o;
  logic signed [CW-1:0] min_x_o, max_x_o, min_y_o, max_y_o, mid_x_o, mid_y_o;

  int fail_count, pending, tests_n, inside_n, reports_n, clipped_n, refused_n;

  // Stimulus controls
  int beats   = 0;
  int gap_pct = 0;
  bit quiet   = 1'b0;

  // Vertices of the current polygon, used to aim some queries at corners
  logic signed [CW-1:0] pick_x [64];
  logic signed [CW-1:0] pick_y [64];
  int                   n_pick = 0;

  polygon_point_test_and_area u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .inside_res_o   (inside_res_o),
    .doubled_area_o (doubled_area_o),
    .min_x_o        (min_x_o),
    .max_x_o        (max_x_o),
    .min_y_o        (min_y_o),
    .max_y_o        (max_y_o),
    .mid_x_o        (mid_x_o),
    .mid_y_o        (mid_y_o)
  );

  polygon_result_checker #(
    .MAX_VERTICES (64),
    .CW           (CW)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .command_i      (command_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .done_i         (done_o),
    .status_i       (status_o),
    .inside_res_i   (inside_res_o),
    .doubled_area_i (doubled_area_o),
    .min_x_i        (min_x_o),
    .max_x_i        (max_x_o),
    .min_y_i        (min_y_o),
    .max_y_i        (max_y_o),
    .mid_x_i        (mid_x_o),
    .mid_y_i        (mid_y_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .tests_o        (tests_n),
    .inside_o       (inside_n),
    .reports_o      (reports_n),
    .clipped_o      (clipped_n),
    .refused_o      (refused_n)
  );

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("polygon_point_test_and_area_tb NOT OK");
    $finish;
  end

  // Random coordinate within +/-span; span 0 means the full range
  function automatic logic signed [CW-1:0] rnd_coord(input int span);
    if (span == 0) return CW'($urandom);
    return CW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // One command beat; start stays high across back-to-back beats
  task automatic send_beat(input cmd_e cmd, input logic signed [CW-1:0] x,
                           input logic signed [CW-1:0] y);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    coord_x_i <= x;
    coord_y_i <= y;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    beats++;
  endtask

  // Hold off until every expected result has come back
  task automatic wait_results_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int                   span, n_verts, n_tests, seq_no, idx;
    logic signed [CW-1:0] qx, qy;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, one and two vertices, a triangle
    gap_pct = 30;
    send_beat(CMD_REPORT, 16'sd0, 16'sd0);
    send_beat(CMD_TEST, 16'sd0, 16'sd0);
    send_beat(CMD_APPEND, 16'sd5, -16'sd7);
    send_beat(CMD_TEST, 16'sd5, -16'sd7);
    send_beat(CMD_TEST, 16'sd6, -16'sd7);
    send_beat(CMD_APPEND, 16'sd100, 16'sd50);
    send_beat(CMD_TEST, 16'sd50, 16'sd20);
    send_beat(CMD_APPEND, -16'sd40, 16'sd90);
    send_beat(CMD_TEST, 16'sd20, 16'sd30);
    send_beat(CMD_TEST, -16'sd100, 16'sd20);
    send_beat(CMD_REPORT, 16'sd0, 16'sd0);
    send_beat(CMD_CLEAR, 16'sd0, 16'sd0);

    // Full-range square walked three times: extreme coordinates, clipped area
    gap_pct = 0;
    repeat (3) begin
      send_beat(CMD_APPEND, -16'sd32768, -16'sd32768);
      send_beat(CMD_APPEND, 16'sd32767, -16'sd32768);
      send_beat(CMD_APPEND, 16'sd32767, 16'sd32767);
      send_beat(CMD_APPEND, -16'sd32768, 16'sd32767);
    end
    send_beat(CMD_TEST, 16'sd0, 16'sd0);
    send_beat(CMD_REPORT, 16'sd0, 16'sd0);
    wait_results_drained();

    // Random polygons: clear, appends, queries, report, occasional noise
    seq_no = 0;
    while (beats < ITEMS) begin
      quiet   = (beats >= ITEMS - 80);
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      case ($urandom_range(0, 3))
        0:       span = 8;
        1:       span = 40;
        2:       span = 1000;
        default: span = 0;
      endcase

      if (seq_no == 0 || $urandom_range(0, 19) == 0) n_verts = $urandom_range(62, 70);
      else if ($urandom_range(0, 5) == 0)            n_verts = $urandom_range(0, 2);
      else if ($urandom_range(0, 7) == 0)            n_verts = $urandom_range(11, 30);
      else                                           n_verts = $urandom_range(3, 10);

      if (seq_no == 0 || $urandom_range(0, 7) != 0) begin
        send_beat(CMD_CLEAR, CW'($urandom), CW'($urandom));
        n_pick = 0;
      end

      for (int k = 0; k < n_verts; k++) begin
        qx = rnd_coord(span);
        qy = rnd_coord(span);
        if (n_pick < 64) begin
          pick_x[n_pick] = qx;
          pick_y[n_pick] = qy;
          n_pick++;
        end
        send_beat(CMD_APPEND, qx, qy);
      end

      n_tests = $urandom_range(2, 6);
      for (int k = 0; k < n_tests; k++) begin
        qx = rnd_coord(span);
        qy = rnd_coord(span);
        case ($urandom_range(0, 6))
          0: begin
            if (n_pick > 0) begin
              idx = $urandom_range(0, n_pick - 1);
              qx  = pick_x[idx];
              qy  = pick_y[idx];
            end
          end
          1: begin
            qx = CW'($urandom);
            qy = CW'($urandom);
          end
          default: ;
        endcase
        send_beat(CMD_TEST, qx, qy);
      end
      send_beat(CMD_REPORT, CW'($urandom), CW'($urandom));

      // Noise: any command with any coordinates
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_beat(cmd_e'($urandom_range(0, 3)), CW'($urandom), CW'($urandom));
      end

      if (seq_no == 25) wait_results_drained();
      seq_no++;
    end

    wait_results_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d beats: %0d point tests (%0d inside), %0d geometry reports",
             beats, tests_n, inside_n, reports_n);
    $display("Clipped area reports: %0d, appends refused on a full table: %0d",
             clipped_n, refused_n);
    if (fail_count == 0) begin
      $display("polygon_point_test_and_area_tb OK");
    end else begin
      $display("polygon_point_test_and_area_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ppta_pkg.sv
hdl/ppta_ctrl.sv
hdl/ppta_dp.sv
hdl/polygon_point_test_and_area.sv
sim/polygon_result_checker.sv
sim/polygon_point_test_and_area_tb.sv
